// File: rtl/u2u_pkg.sv
// Shared types and constants for the UTF-8 to UTF-16 decoder.
`default_nettype none
package u2u_pkg;

  localparam int unsigned QDepth    = 2;
  localparam int unsigned QPtrWidth = $clog2(QDepth);
  localparam int unsigned QCntWidth = $clog2(QDepth + 1);

  localparam logic [15:0] HighSurrBase = 16'hD800;
  localparam logic [15:0] LowSurrBase  = 16'hDC00;
  localparam logic [20:0] MaxCodePoint = 21'h10FFFF;
  localparam logic [10:0] SuppOffset   = 11'd64;   // 0x10000 >> 10
  localparam logic [4:0]  SurrPrefix   = 5'b11011;
  localparam logic [5:0]  HighPrefix   = 6'b110110;
  localparam logic [5:0]  LowPrefix    = 6'b110111;

  // One queue entry: the units caused by one input byte.
  typedef struct packed {
    logic        pair;
    logic [15:0] unit0;
    logic [15:0] unit1;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage
`default_nettype wire

// File: rtl/u2u_byte_if.sv
// Handshake channel that carries one UTF-8 byte per item.
`default_nettype none
interface u2u_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       last_byte;

  modport source (output valid, output byte_in, output last_byte, input ready);
  modport sink (input valid, input byte_in, input last_byte, output ready);
endinterface
`default_nettype wire

// File: rtl/u2u_unit_if.sv
// Handshake channel that carries one UTF-16 code unit per item.
`default_nettype none
interface u2u_unit_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        last_of_run;

  modport source (output valid, output code_unit, output last_of_run, input ready);
  modport sink (input valid, input code_unit, input last_of_run, output ready);
endinterface
`default_nettype wire

// File: rtl/u2u_front.sv
// Front part: accepts bytes, tracks the sequence state and builds queue entries.
`default_nettype none
module u2u_front
  import u2u_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  u2u_byte_if.sink       bytes,
  input  wire q_status_t q_status,
  output logic           push,
  output entry_t         push_entry
);

  typedef enum logic [2:0] {
    CLS_ASCII,
    CLS_INVALID,
    CLS_LEAD4,
    CLS_LEAD3,
    CLS_LEAD2,
    CLS_CONT
  } byte_class_t;

  logic [20:0] code_accum, code_accum_next;
  logic [1:0]  bytes_pending, bytes_pending_next;

  byte_class_t cls;
  logic [7:0]  b;
  logic        accept;
  logic [20:0] shifted;
  logic        bmp_ok, supp_ok;
  logic [10:0] hi_bits;
  logic        has_result;

  assign b            = bytes.byte_in;
  assign bytes.ready  = !q_status.full;
  assign accept       = bytes.valid && bytes.ready;
  assign shifted      = {code_accum[14:0], b[5:0]};
  assign bmp_ok       = (shifted[20:16] == 5'd0) && (shifted[15:11] != SurrPrefix);
  assign supp_ok      = (shifted[20:16] != 5'd0) && (shifted <= MaxCodePoint);
  assign hi_bits      = shifted[20:10] - SuppOffset;

  always_comb begin
    priority if (!b[7])               cls = CLS_ASCII;
    else if (b[7:3] == 5'b11111)      cls = CLS_INVALID;
    else if (b[7:3] == 5'b11110)      cls = CLS_LEAD4;
    else if (b[7:4] == 4'b1110)       cls = CLS_LEAD3;
    else if (b[7:5] == 3'b110)        cls = CLS_LEAD2;
    else                              cls = CLS_CONT;
  end

  always_comb begin
    code_accum_next    = code_accum;
    bytes_pending_next = bytes_pending;
    has_result         = 1'b0;
    push_entry.pair    = 1'b0;
    push_entry.unit0   = {8'd0, b};
    push_entry.unit1   = LowSurrBase | {6'd0, shifted[9:0]};
    unique case (cls)
      CLS_ASCII: begin
        code_accum_next    = '0;
        bytes_pending_next = '0;
        has_result         = 1'b1;
      end
      CLS_INVALID: begin
      end
      CLS_LEAD4: begin
        code_accum_next    = {18'd0, b[2:0]};
        bytes_pending_next = 2'd3;
      end
      CLS_LEAD3: begin
        code_accum_next    = {17'd0, b[3:0]};
        bytes_pending_next = 2'd2;
      end
      CLS_LEAD2: begin
        code_accum_next    = {16'd0, b[4:0]};
        bytes_pending_next = 2'd1;
      end
      CLS_CONT: begin
        // A continuation byte with nothing pending is simply dropped.
        if (bytes_pending != 2'd0) begin
          bytes_pending_next = bytes_pending - 2'd1;
          code_accum_next    = shifted;
          if (bytes_pending == 2'd1) begin
            code_accum_next  = '0;
            has_result       = bmp_ok || supp_ok;
            push_entry.pair  = supp_ok;
            push_entry.unit0 = supp_ok ? (HighSurrBase | {6'd0, hi_bits[9:0]})
                                       : shifted[15:0];
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign push = accept && has_result;

  always_ff @(posedge clk) begin
    if (rst) begin
      code_accum    <= '0;
      bytes_pending <= '0;
    end else if (accept) begin
      if (bytes.last_byte) begin
        code_accum    <= '0;
        bytes_pending <= '0;
      end else begin
        code_accum    <= code_accum_next;
        bytes_pending <= bytes_pending_next;
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/u2u_queue.sv
// Short queue of entries between the front and back parts.
`default_nettype none
module u2u_queue
  import u2u_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  wire entry_t push_entry,
  input  wire logic   pop,
  output entry_t      head,
  output q_status_t   status
);

  entry_t               entries [QDepth];
  logic [QPtrWidth-1:0] wr_ptr, rd_ptr;
  logic [QCntWidth-1:0] count;

  assign head         = entries[rd_ptr];
  assign status.full  = (count == QCntWidth'(QDepth));
  assign status.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPtrWidth'(QDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPtrWidth'(QDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: rtl/u2u_back.sv
// Back part: splits surrogate pairs and drives the output register.
`default_nettype none
module u2u_back
  import u2u_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire entry_t    head,
  input  wire q_status_t q_status,
  output logic           pop,
  u2u_unit_if.source     units
);

  logic        out_valid;
  logic        phase;
  logic [15:0] low_unit;
  logic        load;

  assign load         = !out_valid || units.ready;
  assign pop          = load && !phase && !q_status.empty;
  assign units.valid  = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= 1'b0;
    end else if (load) begin
      if (phase) begin
        // Second half of a pair: the low surrogate held from the entry.
        out_valid         <= 1'b1;
        units.code_unit   <= low_unit;
        units.last_of_run <= 1'b1;
        phase             <= 1'b0;
      end else if (!q_status.empty) begin
        out_valid         <= 1'b1;
        units.code_unit   <= head.unit0;
        units.last_of_run <= !head.pair;
        low_unit          <= head.unit1;
        phase             <= head.pair;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/utf8_to_utf16_decoder.sv
// UTF-8 to UTF-16 decoder top level.
//
// The bytes channel takes one UTF-8 byte per item with a last_byte flag that
// clears the sequence state after that byte. The units channel gives one
// UTF-16 code unit per item; last_of_run marks the final unit that a byte
// causes, so it is low only on the high surrogate of a pair.
// Throughput is one byte per cycle while the queue is not full. Each byte is
// decoded in the cycle it is accepted and any units it causes are written to
// a two-entry queue; the output stage reads one entry per cycle while it is
// empty or its item is taken and no pair is in progress, and an entry that
// holds a surrogate pair keeps the output stage until both halves are out.
// A byte's units enter the queue at the edge that accepts the byte, and the
// output register then loads the first unit from the queue when it can.
// Reset clears the sequence state, the queue and the output register.
// When the receiver stalls the output register holds its item, the queue
// fills, and bytes.ready falls once the queue is full.
`default_nettype none
module utf8_to_utf16_decoder
  import u2u_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  u2u_byte_if.sink   bytes,
  u2u_unit_if.source units
);

  logic      push, pop;
  entry_t    push_entry, head;
  q_status_t q_status;

  u2u_front u_front (
    .clk        (clk),
    .rst        (rst),
    .bytes      (bytes),
    .q_status   (q_status),
    .push       (push),
    .push_entry (push_entry)
  );

  u2u_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .status     (q_status)
  );

  u2u_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .q_status (q_status),
    .pop      (pop),
    .units    (units)
  );

endmodule
`default_nettype wire

// File: rtl/u2u_checker.sv
// Port-level assertions for the decoder and the bind that attaches them.
`default_nettype none
module u2u_checker
  import u2u_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] code_unit,
  input wire logic        last_of_run
);

  // A unit that stalls stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output item dropped while stalled");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  // Only a high surrogate can be followed by more units from the same byte.
  a_mid_is_high: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_of_run |-> code_unit[15:10] == HighPrefix)
    else $error("non-final unit is not a high surrogate");

  a_surr_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid && code_unit[15:11] == SurrPrefix |-> last_of_run == code_unit[10])
    else $error("surrogate half carries the wrong last_of_run");

  a_low_follows: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_of_run
      |=> out_valid && code_unit[15:10] == LowPrefix)
    else $error("high surrogate not followed by low surrogate");

endmodule

bind utf8_to_utf16_decoder u2u_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (units.valid),
  .out_ready   (units.ready),
  .code_unit   (units.code_unit),
  .last_of_run (units.last_of_run)
);
`default_nettype wire

// File: tb/testbench.sv
// Self-checking testbench for the UTF-8 to UTF-16 decoder top level.
`timescale 1ns / 100ps
module testbench;
  import u2u_pkg::*;

  localparam int unsigned RandomItems = 500;
  localparam int unsigned HoldAfter   = 300;
  localparam int unsigned HoldCycles  = 120;
  localparam int unsigned QuietLimit  = 2000;
  localparam int unsigned DrainCycles = 10;

  typedef struct {
    logic [7:0] data;
    logic       is_last;
    logic       drain;
  } utf8_item_t;

  typedef struct {
    logic [15:0] code_unit;
    logic        last_of_run;
  } utf16_unit_t;

  typedef enum logic [1:0] {RxFlow, RxLight, RxHeavy} rx_mode_t;

  logic clk;
  logic rst;

  u2u_byte_if bytes_ch ();
  u2u_unit_if units_ch ();

  utf8_to_utf16_decoder i_dut (
    .clk   (clk),
    .rst   (rst),
    .bytes (bytes_ch),
    .units (units_ch)
  );

  utf8_item_t  pending_bytes[$];
  utf16_unit_t expected_units[$];
  int          exp_count;
  int          bytes_seen;
  int          err_count;
  int          rx_hold_left;
  logic        drain_next;

  // Decoder state mirrored by the predictor.
  logic [20:0] dec_accum;
  logic [1:0]  dec_pending;
  logic        dec_discard;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic queue_byte(input logic [7:0] b, input logic is_last);
    utf8_item_t item;
    item.data    = b;
    item.is_last = is_last;
    item.drain   = drain_next;
    drain_next   = 1'b0;
    pending_bytes.push_back(item);
  endtask

  // Encodes a value in the given form and queues the first keep bytes.
  task automatic queue_point(input int len, input logic [20:0] cp, input int keep);
    logic [7:0] seq[4];
    case (len)
      1: seq[0] = {1'b0, cp[6:0]};
      2: begin
        seq[0] = {3'b110, cp[10:6]};
        seq[1] = {2'b10, cp[5:0]};
      end
      3: begin
        seq[0] = {4'b1110, cp[15:12]};
        seq[1] = {2'b10, cp[11:6]};
        seq[2] = {2'b10, cp[5:0]};
      end
      default: begin
        seq[0] = {5'b11110, cp[20:18]};
        seq[1] = {2'b10, cp[17:12]};
        seq[2] = {2'b10, cp[11:6]};
        seq[3] = {2'b10, cp[5:0]};
      end
    endcase
    for (int i = 0; i < keep; i++) queue_byte(seq[i], $urandom_range(0, 19) == 0);
  endtask

  // Predicts the code units caused by one accepted byte.
  task automatic decode_utf8_byte(input logic [7:0] b, input logic is_last);
    logic [20:0] offs;
    casez (b)
      8'b0???????: begin
        expected_units.push_back('{code_unit: {8'h00, b}, last_of_run: 1'b1});
        dec_accum   = '0;
        dec_pending = '0;
        dec_discard = 1'b0;
      end
      8'b11111???: ;
      8'b11110???: begin
        dec_accum   = {18'd0, b[2:0]};
        dec_pending = 2'd3;
        dec_discard = 1'b0;
      end
      8'b1110????: begin
        dec_accum   = {17'd0, b[3:0]};
        dec_pending = 2'd2;
        dec_discard = 1'b0;
      end
      8'b110?????: begin
        dec_accum   = {16'd0, b[4:0]};
        dec_pending = 2'd1;
        dec_discard = 1'b0;
      end
      default: begin
        if (dec_pending == 2'd0) begin
          dec_discard = 1'b1;
        end else begin
          dec_accum   = {dec_accum[14:0], b[5:0]};
          dec_pending = dec_pending - 2'd1;
          if (dec_pending == 2'd0) begin
            if (dec_accum <= 21'h00D7FF ||
                (dec_accum >= 21'h00E000 && dec_accum <= 21'h00FFFF)) begin
              expected_units.push_back('{code_unit: dec_accum[15:0], last_of_run: 1'b1});
            end else if (dec_accum >= 21'h010000 && dec_accum <= MaxCodePoint) begin
              offs = dec_accum - 21'h010000;
              expected_units.push_back('{code_unit: HighSurrBase | {6'd0, offs[19:10]},
                                         last_of_run: 1'b0});
              expected_units.push_back('{code_unit: LowSurrBase | {6'd0, offs[9:0]},
                                         last_of_run: 1'b1});
            end
            dec_accum = '0;
          end
        end
      end
    endcase
    if (is_last) begin
      dec_accum   = '0;
      dec_pending = '0;
      dec_discard = 1'b0;
    end
  endtask

  initial begin
    int          kind;
    int          len;
    logic [20:0] cp;
    int unsigned target;
    logic        mid_drain_done;

    rst               = 1'b1;
    drain_next        = 1'b0;
    mid_drain_done    = 1'b0;

    // Directed part: field extremes and the corner cases of the byte classes.
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b0);              // dropped while idle
    queue_byte(8'h7F, 1'b0);
    queue_byte(8'hE2, 1'b0);
    queue_byte(8'h82, 1'b0);
    queue_byte(8'hAC, 1'b0);
    queue_byte(8'hF0, 1'b0);
    queue_byte(8'h9F, 1'b0);
    queue_byte(8'hFE, 1'b0);              // dropped inside a sequence
    queue_byte(8'h98, 1'b0);
    queue_byte(8'h80, 1'b0);
    queue_point(4, MaxCodePoint, 4);
    queue_point(4, 21'h110000, 4);        // above the Unicode range
    queue_point(3, 21'h00D800, 3);        // surrogate value is dropped
    queue_byte(8'hBF, 1'b0);              // stray continuation
    queue_byte(8'h80, 1'b0);              // still discarding
    queue_byte(8'hE2, 1'b0);              // abandoned by the next lead
    queue_byte(8'hC0, 1'b0);              // overlong zero
    queue_byte(8'h80, 1'b0);
    queue_byte(8'hC3, 1'b0);
    queue_byte(8'h41, 1'b0);              // ASCII cancels the sequence
    queue_byte(8'hE2, 1'b0);
    queue_byte(8'h82, 1'b1);              // last byte clears the sequence
    queue_byte(8'hAC, 1'b1);

    // Random part: mostly well-formed sequences, the rest broken or noise.
    drain_next = 1'b1;
    target = pending_bytes.size() + RandomItems;
    while (pending_bytes.size() < target) begin
      if (!mid_drain_done && pending_bytes.size() > target - RandomItems / 2) begin
        drain_next     = 1'b1;
        mid_drain_done = 1'b1;
      end
      kind = $urandom_range(0, 9);
      len  = $urandom_range(1, 4);
      cp   = 21'($urandom);
      case (len)
        1: cp = {14'd0, cp[6:0]};
        2: cp = {10'd0, cp[10:0]};
        3: cp = ($urandom_range(0, 7) == 0) ? 21'(21'h00D800 + $urandom_range(0, 11'h7FF))
                                             : {5'd0, cp[15:0]};
        default: if ($urandom_range(0, 2) != 0)
          cp = 21'(21'h010000 + $urandom_range(0, 20'hFFFFF));
      endcase
      if (kind < 7) queue_point(len, cp, len);
      else if (kind == 7 && len > 1) queue_point(len, cp, $urandom_range(1, len - 1));
      else queue_byte(8'($urandom_range(0, 255)), $urandom_range(0, 19) == 0);
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk);
    while (pending_bytes.size() != 0 || bytes_ch.valid || exp_count != 0);
    repeat (DrainCycles) @(negedge clk);

    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Byte driver: bursts of random length separated by random gaps.
  always @(posedge clk) begin : byte_driver
    int   burst_left;
    int   gap_left;
    logic took;
    logic offer;
    if (rst) begin
      bytes_ch.valid     <= 1'b0;
      bytes_ch.byte_in   <= 8'h00;
      bytes_ch.last_byte <= 1'b0;
      burst_left = 1;
      gap_left   = 0;
    end else begin
      took  = bytes_ch.valid && bytes_ch.ready;
      offer = 1'b0;
      if (took) begin
        pending_bytes.delete(0);
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                   : $urandom_range(1, 16);
        end
      end
      if (!bytes_ch.valid || took) begin
        if (gap_left > 0 && rx_hold_left == 0) begin
          gap_left--;
        end else if (pending_bytes.size() != 0) begin
          // A drain item is offered only when no byte was just taken and every unit has come back.
          offer = !pending_bytes[0].drain || (!took && exp_count == 0);
        end
        if (offer) begin
          bytes_ch.byte_in   <= pending_bytes[0].data;
          bytes_ch.last_byte <= pending_bytes[0].is_last;
        end
        bytes_ch.valid <= offer;
      end
    end
  end

  // Unit receiver: random stall modes plus one long hold-off.
  always @(posedge clk) begin : unit_receiver
    rx_mode_t rx_mode;
    int       mode_left;
    logic     hold_done;
    if (rst) begin
      units_ch.ready <= 1'b0;
      rx_hold_left   <= 0;
      rx_mode   = RxFlow;
      mode_left = 0;
      hold_done = 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   = rx_mode_t'($urandom_range(0, 2));
        mode_left = $urandom_range(8, 60);
      end else begin
        mode_left--;
      end
      if (!hold_done && bytes_seen >= HoldAfter) begin
        hold_done = 1'b1;
        rx_hold_left   <= HoldCycles;
        units_ch.ready <= 1'b0;
      end else if (rx_hold_left > 0) begin
        rx_hold_left   <= rx_hold_left - 1;
        units_ch.ready <= 1'b0;
      end else begin
        case (rx_mode)
          RxFlow:  units_ch.ready <= 1'b1;
          RxLight: units_ch.ready <= ($urandom_range(0, 3) != 0);
          default: units_ch.ready <= ($urandom_range(0, 1) != 0);
        endcase
      end
    end
  end

  // Predicts on every accepted byte and checks every accepted unit.
  always @(posedge clk) begin : unit_monitor
    utf16_unit_t want;
    if (rst) begin
      exp_count  <= 0;
      bytes_seen <= 0;
      err_count  = 0;
      dec_accum   = '0;
      dec_pending = '0;
      dec_discard = 1'b0;
    end else begin
      if (bytes_ch.valid && bytes_ch.ready) begin
        decode_utf8_byte(bytes_ch.byte_in, bytes_ch.last_byte);
        bytes_seen <= bytes_seen + 1;
      end
      if (units_ch.valid && units_ch.ready) begin
        if (expected_units.size() == 0) begin
          err_count++;
          $display("%0t: unexpected unit: expected none, actual %h last %0b",
                   $time, units_ch.code_unit, units_ch.last_of_run);
        end else begin
          want = expected_units.pop_front();
          if (units_ch.code_unit !== want.code_unit) begin
            err_count++;
            $display("%0t: code_unit mismatch: expected %h, actual %h",
                     $time, want.code_unit, units_ch.code_unit);
          end
          if (units_ch.last_of_run !== want.last_of_run) begin
            err_count++;
            $display("%0t: last_of_run mismatch: expected %0b, actual %0b",
                     $time, want.last_of_run, units_ch.last_of_run);
          end
        end
      end
      exp_count <= expected_units.size();
    end
  end

  // Ends the run when no item moves on either side for too long.
  always @(posedge clk) begin : watchdog
    int quiet;
    if (rst) begin
      quiet = 0;
    end else begin
      if ((bytes_ch.valid && bytes_ch.ready) || (units_ch.valid && units_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= QuietLimit) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

endmodule

// File: filelist.f
rtl/u2u_pkg.sv
rtl/u2u_byte_if.sv
rtl/u2u_unit_if.sv
rtl/u2u_front.sv
rtl/u2u_queue.sv
rtl/u2u_back.sv
rtl/utf8_to_utf16_decoder.sv
rtl/u2u_checker.sv
tb/testbench.sv
